/* rtl/core/utt_pkg.sv */
// Shared types, constants and the UTF-8 encoding function for the UTF-16 to UTF-8 transcoder.
package utt_pkg;

    // Default depth of the job queue between the front and the back.
    localparam int QueueDepth = 2;

    // Most bytes that one code point yields, and most bytes that one word yields.
    localparam int CpBytes  = 4;
    localparam int JobBytes = 6;

    // Top six bits of a high and of a low surrogate.
    localparam logic [5:0] HighTag = 6'b110110;
    localparam logic [5:0] LowTag  = 6'b110111;

    // Offset added to a surrogate pair's payload.
    localparam logic [20:0] SuppBase = 21'h10000;

    // Range limits of the one-, two- and three-byte forms.
    localparam logic [20:0] Max1Byte = 21'h00007F;
    localparam logic [20:0] Max2Byte = 21'h0007FF;
    localparam logic [20:0] Max3Byte = 21'h00FFFF;

    // Lead byte prefixes and the continuation prefix.
    localparam logic [2:0] Lead2 = 3'b110;
    localparam logic [3:0] Lead3 = 4'b1110;
    localparam logic [4:0] Lead4 = 5'b11110;
    localparam logic [1:0] Cont  = 2'b10;

    // Bytes of one code point, lowest index first on the wire.
    typedef struct packed {
        logic [2:0]                 count;
        logic [CpBytes-1:0][7:0]    bytes;
    } enc_t;

    // Work handed from the front to the back: all bytes that one word causes.
    typedef struct packed {
        logic                       last;
        logic [2:0]                 count;
        logic [JobBytes-1:0][7:0]   bytes;
    } job_t;

    // Encodes one code point (up to 21 bits) as UTF-8.
    function automatic enc_t encode_cp(input logic [20:0] cp);
        enc_t e;
        e = '0;
        priority if (cp <= Max1Byte) begin
            e.bytes[0] = cp[7:0];
            e.count    = 3'd1;
        end else if (cp <= Max2Byte) begin
            e.bytes[0] = {Lead2, cp[10:6]};
            e.bytes[1] = {Cont, cp[5:0]};
            e.count    = 3'd2;
        end else if (cp <= Max3Byte) begin
            e.bytes[0] = {Lead3, cp[15:12]};
            e.bytes[1] = {Cont, cp[11:6]};
            e.bytes[2] = {Cont, cp[5:0]};
            e.count    = 3'd3;
        end else begin
            e.bytes[0] = {Lead4, cp[20:18]};
            e.bytes[1] = {Cont, cp[17:12]};
            e.bytes[2] = {Cont, cp[11:6]};
            e.bytes[3] = {Cont, cp[5:0]};
            e.count    = 3'd4;
        end
        return e;
    endfunction

endpackage

/* rtl/core/utt_front.sv */
// Front end: accepts UTF-16 words, tracks a held high surrogate and builds byte jobs.
module utt_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [15:0]       s_tdata,   // [15:0] code_unit
    input  logic              s_tlast,   // last_unit
    input  logic              q_full,
    output logic              q_push,
    output utt_pkg::job_t     q_job
);

    logic              held_valid_reg, held_valid_next;
    logic [9:0]        held_high_reg, held_high_next;
    logic              s_acc;
    logic              is_high, is_low;
    logic [20:0]       pair_cp;
    utt_pkg::enc_t     pre_enc, unit_enc, pair_enc;
    utt_pkg::job_t     job;

    assign s_tready = !q_full;
    assign s_acc    = s_tvalid && s_tready;

    // Classify the incoming word.
    assign is_high = (s_tdata[15:10] == utt_pkg::HighTag);
    assign is_low  = (s_tdata[15:10] == utt_pkg::LowTag);

    // The three possible encodings: held surrogate alone, current word, combined pair.
    assign pair_cp  = utt_pkg::SuppBase + {1'b0, held_high_reg, s_tdata[9:0]};
    assign pre_enc  = utt_pkg::encode_cp({5'd0, utt_pkg::HighTag, held_high_reg});
    assign unit_enc = utt_pkg::encode_cp({5'd0, s_tdata});
    assign pair_enc = utt_pkg::encode_cp(pair_cp);

    // Assemble the job and the next held state.
    always_comb begin
        job             = '0;
        job.last        = s_tlast;
        held_valid_next = 1'b0;
        held_high_next  = '0;
        if (held_valid_reg && is_low) begin
            job.bytes[utt_pkg::CpBytes-1:0] = pair_enc.bytes;
            job.count                       = pair_enc.count;
        end else begin
            if (held_valid_reg) begin
                job.bytes[2:0] = pre_enc.bytes[2:0];
                job.count      = 3'd3;
            end
            if (is_high && !s_tlast) begin
                held_valid_next = 1'b1;
                held_high_next  = s_tdata[9:0];
            end else begin
                if (held_valid_reg) begin
                    // A single word never needs more than three bytes.
                    for (int i = 0; i < 3; i++) begin
                        job.bytes[i+3] = unit_enc.bytes[i];
                    end
                end else begin
                    job.bytes[utt_pkg::CpBytes-1:0] = unit_enc.bytes;
                end
                job.count = job.count + unit_enc.count;
            end
        end
    end

    assign q_job  = job;
    assign q_push = s_acc && (job.count != 3'd0);

    // Held surrogate state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_valid_reg <= 1'b0;
            held_high_reg  <= '0;
        end else if (s_acc) begin
            held_valid_reg <= held_valid_next;
            held_high_reg  <= held_high_next;
        end
    end

endmodule

/* rtl/core/utt_queue.sv */
// Short job queue that decouples the front end from the byte serializer.
module utt_queue #(
    parameter int DEPTH = utt_pkg::QueueDepth
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  utt_pkg::job_t     push_job,
    output logic              full,
    input  logic              pop,
    output logic              valid,
    output utt_pkg::job_t     pop_job
);

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
    localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

    utt_pkg::job_t      mem [DEPTH];
    logic [PtrW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0]    count_reg, count_next;
    logic               do_push, do_pop;

    assign full    = (count_reg == FullCnt);
    assign valid   = (count_reg != '0);
    assign do_push = push && !full;
    assign do_pop  = pop && valid;
    assign pop_job = mem[rd_ptr_reg];

    // Pointer and fill count updates.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LastPtr) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LastPtr) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Job storage.
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

endmodule

/* rtl/core/utt_back.sv */
// Back end: sends the bytes of each job one word per cycle on the output stream while the receiver is ready.
module utt_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              q_valid,
    input  utt_pkg::job_t     q_job,
    output logic              q_pop,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [7:0]        m_tdata,   // [7:0] out_byte
    output logic              m_tlast,   // run_end
    output logic              m_tuser    // string_end
);

    logic              busy_reg, busy_next;
    logic [2:0]        idx_reg, idx_next;
    utt_pkg::job_t     job_reg;
    logic              m_acc, is_final, done;

    assign m_acc    = m_tvalid && m_tready;
    assign is_final = (idx_reg == (job_reg.count - 3'd1));
    assign done     = m_acc && is_final;
    assign q_pop    = q_valid && (!busy_reg || done);

    // Output word comes straight from the job register.
    assign m_tvalid = busy_reg;
    assign m_tdata  = job_reg.bytes[idx_reg];
    assign m_tlast  = is_final;
    assign m_tuser  = is_final && job_reg.last;

    // Byte index and busy flag.
    always_comb begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        if (q_pop) begin
            busy_next = 1'b1;
            idx_next  = '0;
        end else if (done) begin
            busy_next = 1'b0;
        end else if (m_acc) begin
            idx_next  = idx_reg + 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

    // Load the next job when idle or when the current one is finished.
    always_ff @(posedge aclk) begin
        if (q_pop) begin
            job_reg <= q_job;
        end
    end

endmodule

/* rtl/core/utf16_to_utf8_transcoder.sv */
// Top level of the UTF-16 to UTF-8 transcoder.
//
// Input stream (s_): one UTF-16 code unit per word in s_tdata, s_tlast marks
// the last unit of a string. Output stream (m_): one UTF-8 byte per word in
// m_tdata, m_tlast marks the last byte caused by one input word, and m_tuser
// marks the final byte of the whole string.
// A high surrogate that is not last is held and yields no output by itself;
// it goes out with the next word's bytes, or alone if that word is held too.
// The first byte of a word passes through the job queue and the serializer's
// job register before it appears. The serializer sends one byte per cycle while
// the receiver is ready, and a job holds one to six bytes (four for a surrogate
// pair); the front end takes a word every cycle while the job queue has room.
// When the receiver stalls, the current byte holds and the queue fills; then
// s_tready drops.
// Reset clears the held surrogate, the queue and the serializer; no output
// is valid in the cycle after reset.
module utf16_to_utf8_transcoder #(
    parameter int QUEUE_DEPTH = utt_pkg::QueueDepth
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [15:0]       s_tdata,   // [15:0] code_unit
    input  logic              s_tlast,   // last_unit
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [7:0]        m_tdata,   // [7:0] out_byte
    output logic              m_tlast,   // run_end
    output logic              m_tuser    // string_end
);

    logic              q_full, q_push, q_pop, q_valid;
    utt_pkg::job_t     push_job, pop_job;

    utt_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_job    (push_job)
    );

    utt_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (q_pop),
        .valid    (q_valid),
        .pop_job  (pop_job)
    );

    utt_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_job    (pop_job),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

/* rtl/core/utt_checker.sv */
// Port-level checks of the transcoder, bound to the top level.
module utt_checker (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              m_tvalid,
    input  logic              m_tready,
    input  logic [7:0]        m_tdata,   // [7:0] out_byte
    input  logic              m_tlast,   // run_end
    input  logic              m_tuser    // string_end
);

    // Nothing is offered in the cycle after reset.
    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("output valid right after reset");

    // The end of a string is always the end of a word's bytes.
    a_string_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("string end without run end");

    // A lead byte of a multibyte sequence is never the last byte of a run.
    a_lead_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> (m_tdata[7:6] != 2'b11))
        else $error("run ends on a lead byte");

    // An ASCII byte is always the last byte of its run.
    a_ascii_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[7] |-> m_tlast)
        else $error("ASCII byte not at run end");

    // A stalled output word holds.
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)
            && $stable(m_tlast) && $stable(m_tuser))
        else $error("stalled output word changed");

endmodule

bind utf16_to_utf8_transcoder utt_checker u_checker (.*);

/* dv/tb_top.sv */
// Self-checking testbench for the UTF-16 to UTF-8 transcoder.
module tb_top;

    // One expected UTF-8 byte with its two markers.
    typedef struct packed {
        logic [7:0] data;
        logic       run_end;
        logic       string_end;
    } utf8_byte_t;

    // Predicts the UTF-8 bytes of each accepted code unit and checks the output words.
    class utf8_scoreboard;
        utf8_byte_t  pending_q[$];
        logic [9:0]  held_bits;
        bit          held;
        int          errors;
        int          units_seen;
        int          bytes_checked;

        function new();
            held_bits     = '0;
            held          = 1'b0;
            errors        = 0;
            units_seen    = 0;
            bytes_checked = 0;
        endfunction

        // Appends one expected byte with both markers clear.
        function void add_byte(logic [7:0] data);
            utf8_byte_t b;
            b = '{data, 1'b0, 1'b0};
            pending_q = {pending_q, b};
        endfunction

        // Appends the UTF-8 encoding of one code point.
        function void add_code_point(logic [20:0] cp);
            if (cp <= utt_pkg::Max1Byte) begin
                add_byte(cp[7:0]);
            end else if (cp <= utt_pkg::Max2Byte) begin
                add_byte({utt_pkg::Lead2, cp[10:6]});
                add_byte({utt_pkg::Cont, cp[5:0]});
            end else if (cp <= utt_pkg::Max3Byte) begin
                add_byte({utt_pkg::Lead3, cp[15:12]});
                add_byte({utt_pkg::Cont, cp[11:6]});
                add_byte({utt_pkg::Cont, cp[5:0]});
            end else begin
                add_byte({utt_pkg::Lead4, cp[20:18]});
                add_byte({utt_pkg::Cont, cp[17:12]});
                add_byte({utt_pkg::Cont, cp[11:6]});
                add_byte({utt_pkg::Cont, cp[5:0]});
            end
        endfunction

        // Notes one accepted code unit and queues the bytes it causes.
        function void note_unit(logic [15:0] unit, logic last);
            int  first;
            bit  is_high;
            bit  is_low;
            bit  done;
            first   = pending_q.size();
            is_high = (unit[15:10] == utt_pkg::HighTag);
            is_low  = (unit[15:10] == utt_pkg::LowTag);
            done    = 1'b0;
            units_seen++;
            // A held high surrogate either pairs with this unit or goes out on its own.
            if (held) begin
                held = 1'b0;
                if (is_low) begin
                    add_code_point(utt_pkg::SuppBase + {1'b0, held_bits, unit[9:0]});
                    done = 1'b1;
                end else begin
                    add_code_point({5'b0, utt_pkg::HighTag, held_bits});
                end
                held_bits = '0;
            end
            // A high surrogate that is not last waits for its partner.
            if (!done) begin
                if (is_high && !last) begin
                    held_bits = unit[9:0];
                    held      = 1'b1;
                end else begin
                    add_code_point({5'b0, unit});
                end
            end
            if (pending_q.size() > first) begin
                pending_q[pending_q.size()-1].run_end    = 1'b1;
                pending_q[pending_q.size()-1].string_end = last;
            end
        endfunction

        // Compares one output word with the oldest expected byte.
        function void check_byte(logic [7:0] data, logic run_end, logic string_end);
            utf8_byte_t exp_b;
            if (pending_q.size() == 0) begin
                $display("%0t: unexpected byte %h (run_end %b, string_end %b)",
                         $time, data, run_end, string_end);
                errors++;
            end else begin
                exp_b = pending_q.pop_front();
                bytes_checked++;
                if (data !== exp_b.data) begin
                    $display("%0t: byte mismatch, expected %h, actual %h",
                             $time, exp_b.data, data);
                    errors++;
                end
                if (run_end !== exp_b.run_end) begin
                    $display("%0t: run_end mismatch on byte %h, expected %b, actual %b",
                             $time, exp_b.data, exp_b.run_end, run_end);
                    errors++;
                end
                if (string_end !== exp_b.string_end) begin
                    $display("%0t: string_end mismatch on byte %h, expected %b, actual %b",
                             $time, exp_b.data, exp_b.string_end, string_end);
                    errors++;
                end
            end
        endfunction

        function int outstanding();
            return pending_q.size();
        endfunction
    endclass

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;   // [15:0] code_unit
    logic        s_tlast  = 1'b0; // last_unit
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;         // [7:0] out_byte
    logic        m_tlast;         // run_end
    logic        m_tuser;         // string_end

    utf8_scoreboard sb = new();

    int tx_gap_pct   = 37;
    int rx_stall_pct = 37;
    int hold_tickets = 0;
    int hold_served  = 0;
    int hold_left    = 0;
    int units_sent   = 0;
    int strings_sent = 0;

    utf16_to_utf8_transcoder u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    // Free-running clock.
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Hard stop in case the block hangs.
    initial begin
        #600000;
        $display("simulation failed");
        $finish;
    end

    // Output side: checks each accepted word, stalls at random or for a long hold.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_byte(m_tdata, m_tlast, m_tuser);
        end
        if (hold_tickets != hold_served) begin
            hold_served = hold_served + 1;
            hold_left   = 200;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // Offers one code unit, after random idle cycles, and waits for it to be taken.
    task automatic send_unit(input logic [15:0] unit, input logic last);
        while ($urandom_range(99) < tx_gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= unit;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        sb.note_unit(unit, last);
        units_sent++;
        if (last) strings_sent++;
    endtask

    // Stimulus and end of run.
    initial begin
        logic [15:0] str_q[$];
        logic [15:0] unit;
        int          len;
        int          pick;
        int          n;
        bit          paused;
        bit          held_off;

        paused   = 1'b0;
        held_off = 1'b0;
        aresetn <= 1'b0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Range boundaries of each encoded length.
        send_unit(16'h0000, 1'b0);
        send_unit(16'h007F, 1'b0);
        send_unit(16'h0080, 1'b0);
        send_unit(16'h07FF, 1'b0);
        send_unit(16'h0800, 1'b0);
        send_unit(16'hD7FF, 1'b0);
        send_unit(16'hE000, 1'b0);
        send_unit(16'hFFFF, 1'b1);
        // Surrogate pairs at both ends of the supplementary range.
        send_unit(16'hD800, 1'b0);
        send_unit(16'hDC00, 1'b0);
        send_unit(16'hDBFF, 1'b0);
        send_unit(16'hDFFF, 1'b1);
        // Held high surrogate followed by a plain unit, and by a three-byte last unit.
        send_unit(16'hD801, 1'b0);
        send_unit(16'h0041, 1'b0);
        send_unit(16'hDABC, 1'b0);
        send_unit(16'hFFFF, 1'b1);
        // Held high replaced by a new high, which then pairs with a low.
        send_unit(16'hD900, 1'b0);
        send_unit(16'hDA00, 1'b0);
        send_unit(16'hDC55, 1'b0);
        // Held high followed by a high marked last.
        send_unit(16'hD800, 1'b0);
        send_unit(16'hDBFF, 1'b1);
        // High surrogate marked last, lone lows, and a pair ending the string.
        send_unit(16'hD8AA, 1'b1);
        send_unit(16'hDE00, 1'b0);
        send_unit(16'hDFFF, 1'b1);
        send_unit(16'hDB00, 1'b0);
        send_unit(16'hDD00, 1'b1);

        // Random strings, mostly well-formed text with some broken surrogates.
        while (units_sent < 215) begin
            if (units_sent >= 90 && units_sent < 140) begin
                tx_gap_pct   = 0;
                rx_stall_pct = 0;
            end else begin
                tx_gap_pct   = 37;
                rx_stall_pct = 37;
            end
            str_q.delete();
            len = $urandom_range(1, 8);
            for (int i = 0; i < len; i++) begin
                pick = $urandom_range(99);
                if (pick < 25) begin
                    str_q = {str_q, 16'($urandom_range(16'h0000, 16'h007F))};
                end else if (pick < 40) begin
                    str_q = {str_q, 16'($urandom_range(16'h0080, 16'h07FF))};
                end else if (pick < 55) begin
                    str_q = {str_q, 16'($urandom_range(16'h0800, 16'hD7FF))};
                end else if (pick < 62) begin
                    str_q = {str_q, 16'($urandom_range(16'hE000, 16'hFFFF))};
                end else if (pick < 82) begin
                    str_q = {str_q, 16'($urandom_range(16'hD800, 16'hDBFF))};
                    str_q = {str_q, 16'($urandom_range(16'hDC00, 16'hDFFF))};
                end else if (pick < 90) begin
                    str_q = {str_q, 16'($urandom_range(16'hD800, 16'hDBFF))};
                end else if (pick < 95) begin
                    str_q = {str_q, 16'($urandom_range(16'hDC00, 16'hDFFF))};
                end else begin
                    str_q = {str_q, 16'($urandom)};
                end
            end
            foreach (str_q[i]) begin
                unit = str_q[i];
                send_unit(unit, i == str_q.size() - 1);
            end

            // Let the output drain completely once.
            if (!paused && units_sent >= 60) begin
                paused = 1'b1;
                s_tvalid <= 1'b0;
                while (sb.outstanding() != 0) @(posedge aclk);
            end
            // Long receiver hold while the sender keeps offering units.
            if (!held_off && units_sent >= 160) begin
                held_off = 1'b1;
                hold_tickets = hold_tickets + 1;
            end
        end

        // Wait for the last bytes, then keep watching for anything spurious.
        s_tvalid <= 1'b0;
        tx_gap_pct   = 37;
        rx_stall_pct = 37;
        n = 0;
        while (n < 5000 && sb.outstanding() != 0) begin
            @(posedge aclk);
            n++;
        end
        repeat (20) @(posedge aclk);
        if (sb.outstanding() != 0) begin
            $display("%0t: %0d expected bytes never arrived, next expected %h",
                     $time, sb.outstanding(), sb.pending_q[0].data);
            sb.errors++;
        end

        $display("Run covered %0d code units in %0d strings, %0d UTF-8 bytes checked,",
                 units_sent, strings_sent, sb.bytes_checked);
        $display("with pairs, lone surrogates, a full drain and a long output hold.");
        if (sb.errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/core/utt_pkg.sv
rtl/core/utt_front.sv
rtl/core/utt_queue.sv
rtl/core/utt_back.sv
rtl/core/utf16_to_utf8_transcoder.sv
rtl/core/utt_checker.sv
dv/tb_top.sv
